/* rtl/lru_tag_slot_cache_core_defines.svh */
// Assertion macros used by the slot cache top level
`ifndef LRU_TAG_SLOT_CACHE_CORE_DEFINES_SVH
`define LRU_TAG_SLOT_CACHE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define LTSC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define LTSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ltsc_pkg.sv */
// Types, codes and constants of the slot cache
package ltsc_pkg;

    // Slot count default and index width fixed by the slot_index field
    localparam int DEF_NUM_SLOTS = 8;
    localparam int SLOT_IDX_W    = 6;
    localparam int USED_W        = 7;
    localparam int KB_SHIFT      = 10;

    // Field widths
    localparam int CMD_W  = 2;
    localparam int KEY_W  = 32;
    localparam int TIME_W = 32;
    localparam int LEN_W  = 24;
    localparam int DIM_W  = 16;
    localparam int STAT_W = 2;
    localparam int KB_W   = 20;
    localparam int PROD_W = USED_W + LEN_W;

    // Commands
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_STATS  = 2'd3;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_MISS   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_REJECT = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEF_W    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEF_H    = 2'd2;
    localparam int CFG_DATA_W = 24;

    // Configuration reset values
    localparam logic [LEN_W-1:0] RST_CAPACITY = 24'd580608;
    localparam logic [DIM_W-1:0] RST_DEF_W    = 16'd1024;
    localparam logic [DIM_W-1:0] RST_DEF_H    = 16'd1024;

    // Slot write operations broadcast to the cells
    localparam int WR_OP_W = 2;
    localparam logic [WR_OP_W-1:0] WR_NONE  = 2'd0;
    localparam logic [WR_OP_W-1:0] WR_TOUCH = 2'd1;
    localparam logic [WR_OP_W-1:0] WR_FILL  = 2'd2;
    localparam logic [WR_OP_W-1:0] WR_CLEAR = 2'd3;

    // Input item payload, last field in the low bits
    typedef struct packed {
        logic [DIM_W-1:0]  item_height;
        logic [DIM_W-1:0]  item_width;
        logic [LEN_W-1:0]  item_length;
        logic [TIME_W-1:0] now_time;
        logic [KEY_W-1:0]  key_hash;
    } in_t;

    // Result item payload, last field in the low bits
    typedef struct packed {
        logic [3:0]            pad;
        logic [KB_W-1:0]       held_kbytes;
        logic [USED_W-1:0]     used_count;
        logic [DIM_W-1:0]      stored_height;
        logic [DIM_W-1:0]      stored_width;
        logic [LEN_W-1:0]      stored_length;
        logic                  evicted;
        logic [SLOT_IDX_W-1:0] slot_index;
        logic [STAT_W-1:0]     status;
    } res_t;

    // Search token walking the cell chain
    typedef struct packed {
        logic                  valid;
        logic [KEY_W-1:0]      key;
        logic                  hit;
        logic [SLOT_IDX_W-1:0] hit_idx;
        logic [LEN_W-1:0]      hit_len;
        logic [DIM_W-1:0]      hit_w;
        logic [DIM_W-1:0]      hit_h;
        logic                  empty;
        logic [SLOT_IDX_W-1:0] empty_idx;
        logic                  min_ok;
        logic [TIME_W-1:0]     min_time;
        logic [SLOT_IDX_W-1:0] min_idx;
        logic [USED_W-1:0]     used;
    } scan_t;

    // Slot write broadcast
    typedef struct packed {
        logic [WR_OP_W-1:0]    op;
        logic [SLOT_IDX_W-1:0] idx;
        logic [KEY_W-1:0]      key;
        logic [LEN_W-1:0]      len;
        logic [TIME_W-1:0]     stamp;
        logic [DIM_W-1:0]      w;
        logic [DIM_W-1:0]      h;
    } wr_t;

endpackage

/* rtl/ltsc_slot_cell.sv */
// One directory slot: holds its entry and updates the passing search token
module ltsc_slot_cell
    import ltsc_pkg::*;
#(
    parameter int SLOT_ID = 0
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  scan_t tok_in,
    output scan_t tok_out,
    input  wr_t   wr
);

    localparam logic [SLOT_IDX_W-1:0] MY_IDX = SLOT_IDX_W'(SLOT_ID);

    logic [KEY_W-1:0]  key_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [TIME_W-1:0] time_reg;
    logic [DIM_W-1:0]  w_reg;
    logic [DIM_W-1:0]  h_reg;
    scan_t             tok_reg;
    scan_t             tok_next;
    logic              sel;

    assign sel = (wr.idx == MY_IDX);

    // Fold this slot into the token
    always_comb
    begin
        tok_next = tok_in;
        if (!tok_in.hit && key_reg == tok_in.key && len_reg != '0)
        begin
            tok_next.hit     = 1'b1;
            tok_next.hit_idx = MY_IDX;
            tok_next.hit_len = len_reg;
            tok_next.hit_w   = w_reg;
            tok_next.hit_h   = h_reg;
        end
        if (!tok_in.empty && key_reg == '0)
        begin
            tok_next.empty     = 1'b1;
            tok_next.empty_idx = MY_IDX;
        end
        // strict compare keeps the lowest index on a tie
        if (!tok_in.min_ok || time_reg < tok_in.min_time)
        begin
            tok_next.min_ok   = 1'b1;
            tok_next.min_time = time_reg;
            tok_next.min_idx  = MY_IDX;
        end
        if (len_reg != '0)
        begin
            tok_next.used = tok_in.used + USED_W'(1);
        end
    end

    // Token hand-off to the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

    // Key, length and time: cleared by reset and by the clear command
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg  <= '0;
            len_reg  <= '0;
            time_reg <= '0;
        end
        else
        begin
            unique case (wr.op)
                WR_CLEAR:
                begin
                    key_reg  <= '0;
                    len_reg  <= '0;
                    time_reg <= '0;
                end
                WR_FILL:
                begin
                    if (sel)
                    begin
                        key_reg  <= wr.key;
                        len_reg  <= wr.len;
                        time_reg <= wr.stamp;
                    end
                end
                WR_TOUCH:
                begin
                    if (sel)
                    begin
                        time_reg <= wr.stamp;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Width and height: meaningful only once filled
    always_ff @(posedge clk)
    begin
        if (wr.op == WR_FILL && sel)
        begin
            w_reg <= wr.w;
            h_reg <= wr.h;
        end
    end

endmodule

/* rtl/lru_tag_slot_cache_core.sv */
// Top level of the fully associative LRU slot cache
// Fully associative slot directory with timestamp LRU replacement. Each item
// (command in s_tuser) is taken when the block is idle; a search token then
// walks the chain of NUM_SLOTS slot cells, one cell per cycle, collecting the
// first hit, the first empty slot, the oldest slot and the occupancy. A
// register captures the finished token; the finish state then applies the
// slot update and loads the result register while no previous result still
// waits on m_tready. The next item is accepted while a result still waits on
// m_tready. Configuration writes are taken in any cycle and must only be
// issued while the block is idle.
`include "lru_tag_slot_cache_core_defines.svh"

module lru_tag_slot_cache_core
    import ltsc_pkg::*;
#(
    parameter int NUM_SLOTS = DEF_NUM_SLOTS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [119:0]          s_tdata,  // key_hash, now_time, item_length, item_width, item_height
    input  logic [CMD_W-1:0]      s_tuser,  // command
    // result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [95:0]           m_tdata,  // status, slot_index, evicted, stored_length,
                                            // stored_width, stored_height, used_count,
                                            // held_kbytes, zero pad
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic             start_reg;
    in_t              item_reg;
    logic [CMD_W-1:0] cmd_reg;
    scan_t            done_reg;
    scan_t            tok [NUM_SLOTS+1];
    wr_t              wr;
    res_t             res;
    res_t             res_reg;
    logic             m_tvalid_reg, m_tvalid_next;
    logic             fin_go;
    logic             accept;

    logic [LEN_W-1:0]  cap_reg;
    logic [DIM_W-1:0]  defw_reg;
    logic [DIM_W-1:0]  defh_reg;

    logic [LEN_W-1:0]      clamp_len;
    logic [DIM_W-1:0]      ins_w;
    logic [DIM_W-1:0]      ins_h;
    logic [SLOT_IDX_W-1:0] victim;
    logic [PROD_W-1:0]     prod;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg  <= RST_CAPACITY;
            defw_reg <= RST_DEF_W;
            defh_reg <= RST_DEF_H;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_CAPACITY: cap_reg  <= cfg_data;
                CFG_DEF_W:    defw_reg <= cfg_data[DIM_W-1:0];
                CFG_DEF_H:    defh_reg <= cfg_data[DIM_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Input side
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_t'(s_tdata);
            cmd_reg  <= s_tuser;
        end
        if (tok[NUM_SLOTS].valid)
        begin
            done_reg <= tok[NUM_SLOTS];
        end
    end

    // Sequencer
    assign fin_go = (state_reg == S_FIN) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (accept) state_next = S_SCAN;
            S_SCAN: if (tok[NUM_SLOTS].valid) state_next = S_FIN;
            S_FIN:  if (fin_go) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            start_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= accept;
        end
    end

    // Fresh token at the head of the chain
    always_comb
    begin
        tok[0]           = '0;
        tok[0].valid     = start_reg;
        tok[0].key       = item_reg.key_hash;
    end

    // Cell chain
    for (genvar g = 0; g < NUM_SLOTS; g++)
    begin : g_cell
        ltsc_slot_cell #(
            .SLOT_ID (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (tok[g]),
            .tok_out (tok[g+1]),
            .wr      (wr)
        );
    end

    // Insert operands
    assign clamp_len = (item_reg.item_length > cap_reg) ? cap_reg : item_reg.item_length;
    assign ins_w     = (item_reg.item_width == '0) ? defw_reg : item_reg.item_width;
    assign ins_h     = (item_reg.item_height == '0) ? defh_reg : item_reg.item_height;
    assign victim    = done_reg.empty ? done_reg.empty_idx : done_reg.min_idx;
    assign prod      = PROD_W'(done_reg.used) * PROD_W'(cap_reg);

    // Result and slot update
    always_comb
    begin
        res      = '0;
        wr       = '0;
        wr.op    = WR_NONE;
        wr.key   = item_reg.key_hash;
        wr.stamp = item_reg.now_time;
        wr.len   = clamp_len;
        wr.w     = ins_w;
        wr.h     = ins_h;
        unique case (cmd_reg)
            CMD_LOOKUP:
            begin
                if (done_reg.hit)
                begin
                    res.slot_index    = done_reg.hit_idx;
                    res.stored_length = done_reg.hit_len;
                    res.stored_width  = done_reg.hit_w;
                    res.stored_height = done_reg.hit_h;
                    wr.op             = WR_TOUCH;
                    wr.idx            = done_reg.hit_idx;
                end
                else
                begin
                    res.status = STAT_MISS;
                end
            end
            CMD_INSERT:
            begin
                if (item_reg.item_length == '0)
                begin
                    res.status = STAT_REJECT;
                end
                else
                begin
                    res.slot_index    = victim;
                    res.evicted       = !done_reg.empty;
                    res.stored_length = clamp_len;
                    res.stored_width  = ins_w;
                    res.stored_height = ins_h;
                    wr.op             = WR_FILL;
                    wr.idx            = victim;
                end
            end
            CMD_CLEAR:
            begin
                wr.op = WR_CLEAR;
            end
            CMD_STATS:
            begin
                res.used_count  = done_reg.used;
                res.held_kbytes = prod[KB_SHIFT +: KB_W];
            end
            default:
            begin
            end
        endcase
        if (!fin_go)
        begin
            wr.op = WR_NONE;
        end
    end

    // Output register
    assign m_tvalid_next = fin_go ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_go)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = res_reg;

    // Checks
    `LTSC_ASSERT_NEXT(a_accept_starts_scan, clk, rst_n, accept, (state_reg == S_SCAN) && start_reg, "accepted item did not start a scan")
    `LTSC_ASSERT_NOW(a_token_end_in_scan, clk, rst_n, tok[NUM_SLOTS].valid, state_reg == S_SCAN, "token left the chain outside a scan")
    `LTSC_ASSERT_NEXT(a_finish_loads_result, clk, rst_n, fin_go, m_tvalid && (state_reg == S_IDLE), "finish did not present a result")
    `LTSC_ASSERT_NOW(a_used_bounded, clk, rst_n, m_tvalid, res_reg.used_count <= USED_W'(NUM_SLOTS), "occupancy above slot count")

endmodule
